FILE: hw/rtl/jtpd_pkg.sv
// Shared types, constants and tables of the joystick to three-pump drive block.
package jtpd_pkg;

    // Datapath widths
    localparam int CW  = 34;   // CORDIC x/y
    localparam int ZW  = 27;   // angles, degrees in Q16
    localparam int DVW = 40;   // divider dividend
    localparam int DSW = 24;   // divider divisor
    localparam int QB  = 16;   // quotient bits

    // Angles in degrees, Q16
    localparam logic signed [ZW-1:0] DEG_30  = ZW'(30 * 65536);
    localparam logic signed [ZW-1:0] DEG_90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG_150 = ZW'(150 * 65536);
    localparam logic signed [ZW-1:0] DEG_180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] DEG_210 = ZW'(210 * 65536);
    localparam logic signed [ZW-1:0] DEG_270 = ZW'(270 * 65536);
    localparam logic signed [ZW-1:0] DEG_330 = ZW'(330 * 65536);
    localparam logic signed [ZW-1:0] DEG_360 = ZW'(360 * 65536);

    // Fixed-point constants
    localparam logic [15:0] SHARE_HALF = 16'd16384;
    localparam logic [15:0] SHARE_ONE  = 16'd32768;
    localparam logic [16:0] INV_SQRT3  = 17'd37837;   // 1/sqrt3, Q0.16
    localparam logic [15:0] LEN_SCALE  = 16'd45875;   // 0.7, Q0.16
    localparam logic [CW-1:0] UNIT_X   = CW'(1 << 20);

    // Register map indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_MAX_A    = 3'd2;
    localparam logic [2:0] REG_MAX_B    = 3'd3;
    localparam logic [2:0] REG_MAX_C    = 3'd4;
    localparam logic [2:0] REG_MIN      = 3'd5;

    // Sector codes
    localparam logic [1:0] SECT_0 = 2'd0;
    localparam logic [1:0] SECT_1 = 2'd1;
    localparam logic [1:0] SECT_2 = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_VEC_GO,
        ST_VEC_RUN,
        ST_THETA,
        ST_SECT,
        ST_ROT_GO,
        ST_ROT_RUN,
        ST_HMUL,
        ST_HCHK,
        ST_HDIV,
        ST_LEN,
        ST_PMUL,
        ST_NMUL,
        ST_DCHK,
        ST_DDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_ctl_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = ZW'(2949120);
            5'd1:  v = ZW'(1740967);
            5'd2:  v = ZW'(919879);
            5'd3:  v = ZW'(466945);
            5'd4:  v = ZW'(234379);
            5'd5:  v = ZW'(117304);
            5'd6:  v = ZW'(58666);
            5'd7:  v = ZW'(29335);
            5'd8:  v = ZW'(14668);
            5'd9:  v = ZW'(7334);
            5'd10: v = ZW'(3667);
            5'd11: v = ZW'(1833);
            5'd12: v = ZW'(917);
            5'd13: v = ZW'(458);
            5'd14: v = ZW'(229);
            5'd15: v = ZW'(115);
            5'd16: v = ZW'(57);
            5'd17: v = ZW'(29);
            5'd18: v = ZW'(14);
            5'd19: v = ZW'(7);
            5'd20: v = ZW'(4);
            5'd21: v = ZW'(2);
            5'd22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Pump driven by a sector: k=0 takes the low share, k=1 the high share
    function automatic logic [1:0] pump_of(input logic [1:0] sec, input logic k);
        logic [1:0] p;
        case ({sec, k})
            {SECT_0, 1'b0}: p = 2'd1;
            {SECT_0, 1'b1}: p = 2'd2;
            {SECT_1, 1'b0}: p = 2'd2;
            {SECT_1, 1'b1}: p = 2'd0;
            {SECT_2, 1'b0}: p = 2'd0;
            default:        p = 2'd1;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/jtpd_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
module jtpd_cordic #(
    parameter int STEPS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  jtpd_pkg::cordic_ctl_t          ctl,
    input  logic signed [jtpd_pkg::CW-1:0] x_in,
    input  logic signed [jtpd_pkg::CW-1:0] y_in,
    input  logic signed [jtpd_pkg::ZW-1:0] z_in,
    output logic                           busy,
    output logic signed [jtpd_pkg::CW-1:0] x_out,
    output logic signed [jtpd_pkg::CW-1:0] y_out,
    output logic signed [jtpd_pkg::ZW-1:0] z_out
);
    import jtpd_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic                 busy_reg;
    logic                 rot_reg;
    logic [IW-1:0]        step_reg;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] ang;
    logic                 turn_neg;

    // one micro-rotation
    always_comb begin
        xs       = x_reg >>> step_reg;
        ys       = y_reg >>> step_reg;
        ang      = atan_q16(5'(step_reg));
        turn_neg = rot_reg ? (z_reg < 0) : (y_reg > 0);
        if (turn_neg) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + ang;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - ang;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ctl.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == IW'(STEPS - 1)) begin
            busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rot_reg  <= ctl.rotate;
            step_reg <= '0;
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

FILE: hw/rtl/jtpd_isqrt.sv
// Integer square root, one result bit per cycle.
module jtpd_isqrt #(
    parameter int RB = 11
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*RB-1:0] n_in,
    output logic            busy,
    output logic [RB-1:0]   root
);
    logic [2*RB-1:0] rem_reg, root_reg, bit_reg, trial;

    assign trial = root_reg + bit_reg;

    // run while the trial bit is still in range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else if (start) begin
            bit_reg <= (2*RB)'(1) << (2*RB - 2);
        end else begin
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= n_in;
            root_reg <= '0;
        end else if (bit_reg != '0) begin
            if (rem_reg >= trial) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
        end
    end

    assign busy = (bit_reg != '0);
    assign root = root_reg[RB-1:0];

endmodule

FILE: hw/rtl/jtpd_div.sv
// Restoring divider, one quotient bit per cycle; dividend must be below divisor * 2^QB.
module jtpd_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [jtpd_pkg::DVW-1:0] dividend,
    input  logic [jtpd_pkg::DSW-1:0] divisor,
    output logic                     busy,
    output logic [jtpd_pkg::QB-1:0]  quot
);
    import jtpd_pkg::*;

    localparam int KW = $clog2(QB);

    logic           busy_reg;
    logic [KW-1:0]  k_reg;
    logic [DVW-1:0] rem_reg, trial;
    logic [DSW-1:0] dvs_reg;
    logic [QB-1:0]  q_reg;

    assign trial = DVW'(dvs_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && k_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            q_reg   <= '0;
            k_reg   <= KW'(QB - 1);
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_reg      <= rem_reg - trial;
                q_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 1'b1;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

FILE: hw/rtl/joystick_to_three_pump_drive.sv
// Top level: joystick sample in, three pump drive levels out, APB register port.
//
// Takes one joystick sample at a time and returns one result per sample. A new sample
// can be taken in the cycle after the result of the last one is loaded, not before. The
// time per sample is set by the shared iterative units: up to two CORDIC passes, a divide
// for the high share and one for each of the two active pumps where needed, plus the
// steps of the state machine between them. The square root runs alongside the CORDIC
// passes. A finished result waits in the output register while the next sample is
// taken; a result still held there when the next one is ready stalls the block until it
// is taken. The user must write registers only while no sample is in flight; the block
// itself does not enforce this.
module joystick_to_three_pump_drive #(
    parameter int SAMPLE_BITS  = 10,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // x_sample, y_sample, button_level
    input  logic [((2*SAMPLE_BITS+1+7)/8)*8-1:0]          s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // drive_a, drive_b, drive_c
    output logic [23:0]                                   m_tdata,
    // reverse_mode, sector
    output logic [2:0]                                    m_tuser,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [4:0]                                    paddr,
    input  logic [31:0]                                   pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);
    import jtpd_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CXW  = (SB > 10) ? SB : 10;
    localparam int DXW  = CXW + 1;
    localparam int RB   = CXW + 1;
    localparam int SQW  = 2 * RB;
    localparam int LW   = RB + 16;
    localparam int PW   = 16 + LW;
    localparam int NW   = PW + 11;
    localparam int AW   = NW - 31;
    localparam int HNW  = 26;
    localparam int MW   = 41;

    // configuration registers
    logic [CXW-1:0] cx_reg, cy_reg;
    logic [7:0]     max_a_reg, max_b_reg, max_c_reg, min_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    // control
    state_t state_reg, state_next;
    logic   flag_reg, flag_next, latch_reg, latch_next;
    logic   k_reg, k_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept, out_load;

    // payload
    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic [SQW-1:0]        sq_reg;
    logic                  flip_reg;
    logic signed [ZW-1:0]  theta_reg, s_reg;
    logic [1:0]            sector_reg;
    logic signed [CW-1:0]  cos_reg;
    logic signed [MW-1:0]  hmul_reg;
    logic [15:0]           hi_reg;
    logic [LW-1:0]         len_reg;
    logic [PW-1:0]         p_reg;
    logic [15:0]           mnmx_reg;
    logic signed [8:0]     diff_reg;
    logic [7:0]            mx_reg;
    logic signed [NW-1:0]  dnum_reg;
    logic [7:0]            drv_reg [3];
    logic [23:0]           m_data_reg;
    logic [2:0]            m_user_reg;

    // unit connections
    cordic_ctl_t          cor_ctl;
    logic signed [CW-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [ZW-1:0] cor_z_in, cor_z;
    logic                 cor_busy;
    logic                 sqrt_start, sqrt_busy;
    logic [RB-1:0]        sqrt_root;
    logic                 div_start, div_busy;
    logic [DVW-1:0]       div_dvd;
    logic [DSW-1:0]       div_dvs;
    logic [QB-1:0]        div_q;

    // decode helpers
    logic                  special;
    logic signed [ZW-1:0]  theta_calc, t_sum, t_norm, t_rev;
    logic [1:0]            sect_calc;
    logic signed [ZW-1:0]  s_calc;
    logic signed [HNW-1:0] hnum, cos4, cos_n;
    logic                  hchk_div;
    logic [15:0]           hi_direct;
    logic signed [AW-1:0]  dq, mx_lim;
    logic                  dchk_div;
    logic [7:0]            drv_direct;
    logic [1:0]            pump;
    logic [7:0]            mx_sel;
    logic [15:0]           share;
    logic signed [DXW-1:0] dxn, dyn;

    // ---------------------------------------------------------------------------------
    // APB register port
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg    <= CXW'(512);
            cy_reg    <= CXW'(512);
            max_a_reg <= 8'd255;
            max_b_reg <= 8'd255;
            max_c_reg <= 8'd255;
            min_reg   <= 8'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CENTER_X: cx_reg    <= CXW'(pwdata[SB-1:0]);
                REG_CENTER_Y: cy_reg    <= CXW'(pwdata[SB-1:0]);
                REG_MAX_A:    max_a_reg <= pwdata[7:0];
                REG_MAX_B:    max_b_reg <= pwdata[7:0];
                REG_MAX_C:    max_c_reg <= pwdata[7:0];
                REG_MIN:      min_reg   <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X: prdata = 32'(cx_reg);
            REG_CENTER_Y: prdata = 32'(cy_reg);
            REG_MAX_A:    prdata = 32'(max_a_reg);
            REG_MAX_B:    prdata = 32'(max_b_reg);
            REG_MAX_C:    prdata = 32'(max_c_reg);
            REG_MIN:      prdata = 32'(min_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Iterative units
    jtpd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cor_ctl),
        .x_in    (cor_x_in),
        .y_in    (cor_y_in),
        .z_in    (cor_z_in),
        .busy    (cor_busy),
        .x_out   (cor_x),
        .y_out   (cor_y),
        .z_out   (cor_z)
    );

    jtpd_isqrt #(.RB(RB)) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .n_in    (sq_reg),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    jtpd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quot     (div_q)
    );

    // ---------------------------------------------------------------------------------
    // Combinational decode
    assign accept   = s_tvalid & s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign special  = (dy_reg == '0) || (dx_reg == '0);

    // vectoring start: fold the offset into the right half plane
    always_comb begin
        dxn = (dx_reg < 0) ? -dx_reg : dx_reg;
        dyn = (dx_reg < 0) ? -dy_reg : dy_reg;
        if (state_reg == ST_VEC_GO) begin
            cor_x_in = CW'(dxn) <<< 12;
            cor_y_in = CW'(dyn) <<< 12;
            cor_z_in = '0;
        end else begin
            cor_x_in = UNIT_X;
            cor_y_in = '0;
            cor_z_in = s_reg;
        end
    end

    // direction angle, with axis cases and the reverse turn
    always_comb begin
        t_sum = (flip_reg ? DEG_180 : '0) + cor_z;
        if (t_sum < 0) begin
            t_norm = t_sum + DEG_360;
        end else if (t_sum >= DEG_360) begin
            t_norm = t_sum - DEG_360;
        end else begin
            t_norm = t_sum;
        end
        if (dy_reg == '0) begin
            theta_calc = (dx_reg >= 0) ? '0 : DEG_180;
        end else if (dx_reg == '0) begin
            theta_calc = (dy_reg > 0) ? DEG_90 : DEG_270;
        end else begin
            theta_calc = t_norm;
        end
        t_rev = theta_calc + DEG_180;
        if (flag_reg) begin
            theta_calc = (t_rev >= DEG_360) ? t_rev - DEG_360 : t_rev;
        end
    end

    // sector and offset from its middle
    always_comb begin
        if (theta_reg >= DEG_30 && theta_reg < DEG_150) begin
            sect_calc = SECT_0;
            s_calc    = theta_reg - DEG_90;
        end else if (theta_reg >= DEG_150 && theta_reg < DEG_270) begin
            sect_calc = SECT_1;
            s_calc    = theta_reg - DEG_210;
        end else begin
            sect_calc = SECT_2;
            s_calc    = (theta_reg >= DEG_270) ? theta_reg - DEG_330 : theta_reg + DEG_30;
        end
    end

    // high share checks
    always_comb begin
        cos_n     = HNW'(cos_reg);
        hnum      = cos_n + HNW'(hmul_reg >>> 16);
        cos4      = cos_n <<< 2;
        hchk_div  = 1'b0;
        hi_direct = SHARE_ONE;
        if (cos_reg <= 0) begin
            hi_direct = SHARE_HALF;
        end else if (hnum <= 0) begin
            hi_direct = '0;
        end else if (hnum < cos4) begin
            hchk_div = 1'b1;
        end
    end

    // drive checks
    always_comb begin
        dq         = AW'(dnum_reg >>> 31);
        mx_lim     = AW'($signed({1'b0, mx_reg, 8'b0}));
        dchk_div   = 1'b0;
        drv_direct = 8'd255;
        if (mx_reg == '0) begin
            drv_direct = min_reg;
        end else if (dnum_reg <= 0) begin
            drv_direct = '0;
        end else if (dq < mx_lim) begin
            dchk_div = 1'b1;
        end
    end

    // shared divider operands
    always_comb begin
        if (state_reg == ST_HCHK) begin
            div_dvd = DVW'(unsigned'(hnum)) << 14;
            div_dvs = DSW'(unsigned'(cos_reg));
        end else begin
            div_dvd = DVW'(unsigned'(dq));
            div_dvs = DSW'(mx_reg);
        end
    end

    // pump of the current pass
    always_comb begin
        pump  = pump_of(sector_reg, k_reg);
        share = k_reg ? hi_reg : (SHARE_ONE - hi_reg);
        case (pump)
            2'd0:    mx_sel = max_a_reg;
            2'd1:    mx_sel = max_b_reg;
            default: mx_sel = max_c_reg;
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_SQX;
            ST_SQX:     state_next = ST_SQY;
            ST_SQY:     state_next = ST_VEC_GO;
            ST_VEC_GO:  state_next = special ? ST_THETA : ST_VEC_RUN;
            ST_VEC_RUN: if (!cor_busy) state_next = ST_THETA;
            ST_THETA:   state_next = ST_SECT;
            ST_SECT:    state_next = ST_ROT_GO;
            ST_ROT_GO:  state_next = ST_ROT_RUN;
            ST_ROT_RUN: if (!cor_busy) state_next = ST_HMUL;
            ST_HMUL:    state_next = ST_HCHK;
            ST_HCHK:    state_next = hchk_div ? ST_HDIV : ST_LEN;
            ST_HDIV:    if (!div_busy) state_next = ST_LEN;
            ST_LEN:     if (!sqrt_busy) state_next = ST_PMUL;
            ST_PMUL:    state_next = ST_NMUL;
            ST_NMUL:    state_next = ST_DCHK;
            ST_DCHK: begin
                if (dchk_div) begin
                    state_next = ST_DDIV;
                end else begin
                    state_next = k_reg ? ST_DONE : ST_PMUL;
                end
            end
            ST_DDIV:    if (!div_busy) state_next = k_reg ? ST_DONE : ST_PMUL;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready       = 1'b0;
        cor_ctl.start  = 1'b0;
        cor_ctl.rotate = 1'b0;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_VEC_GO: begin
                cor_ctl.start = !special;
                sqrt_start    = 1'b1;
            end
            ST_ROT_GO: begin
                cor_ctl.start  = 1'b1;
                cor_ctl.rotate = 1'b1;
            end
            ST_HCHK:   div_start = hchk_div;
            ST_DCHK:   div_start = dchk_div;
            default:   ;
        endcase
    end

    // control registers
    always_comb begin
        flag_next    = flag_reg;
        latch_next   = latch_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            // rising button edge toggles, latch follows the button
            flag_next  = flag_reg ^ (s_tdata[2*SB] & !latch_reg);
            latch_next = s_tdata[2*SB];
            k_next     = 1'b0;
        end
        if ((state_reg == ST_DCHK && !dchk_div) || (state_reg == ST_DDIV && !div_busy)) begin
            k_next = 1'b1;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flag_reg    <= 1'b0;
            latch_reg   <= 1'b0;
            k_reg       <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            latch_reg   <= latch_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    dx_reg     <= $signed({1'b0, CXW'(s_tdata[SB-1:0])})
                                  - $signed({1'b0, cx_reg});
                    dy_reg     <= $signed({1'b0, CXW'(s_tdata[2*SB-1:SB])})
                                  - $signed({1'b0, cy_reg});
                    drv_reg[0] <= '0;
                    drv_reg[1] <= '0;
                    drv_reg[2] <= '0;
                end
            end
            ST_SQX:    sq_reg <= SQW'(SQW'(dx_reg) * SQW'(dx_reg));
            ST_SQY:    sq_reg <= sq_reg + SQW'(SQW'(dy_reg) * SQW'(dy_reg));
            ST_VEC_GO: flip_reg <= (dx_reg < 0);
            ST_THETA:  theta_reg <= theta_calc;
            ST_SECT: begin
                sector_reg <= sect_calc;
                s_reg      <= s_calc;
            end
            ST_HMUL: begin
                cos_reg  <= cor_x;
                hmul_reg <= MW'($signed(cor_y[23:0])) * MW'($signed(INV_SQRT3));
            end
            ST_HCHK:   hi_reg <= hi_direct;
            ST_HDIV: begin
                if (!div_busy) begin
                    hi_reg <= (div_q > SHARE_ONE) ? SHARE_ONE : div_q;
                end
            end
            ST_LEN:    len_reg <= LW'(sqrt_root) * LW'(LEN_SCALE);
            ST_PMUL: begin
                p_reg    <= PW'(share) * PW'(len_reg);
                mnmx_reg <= 16'(mx_sel) * 16'(min_reg);
                diff_reg <= $signed({1'b0, mx_sel}) - $signed({1'b0, min_reg});
                mx_reg   <= mx_sel;
            end
            ST_NMUL: begin
                dnum_reg <= NW'($signed({1'b0, p_reg})) * NW'(diff_reg)
                            + (NW'(mnmx_reg) << 31);
            end
            ST_DCHK: begin
                if (!dchk_div) begin
                    drv_reg[pump] <= drv_direct;
                end
            end
            ST_DDIV: begin
                if (!div_busy) begin
                    drv_reg[pump] <= div_q[7:0];
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_data_reg <= {drv_reg[2], drv_reg[1], drv_reg[0]};
                    m_user_reg <= {sector_reg, flag_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: dv/joystick_to_three_pump_drive_test.sv
// Testbench for the joystick to three-pump drive block, checked against a local predictor.
`timescale 1ns / 1ps

module joystick_to_three_pump_drive_test;
    import jtpd_pkg::*;

    localparam int NSTEP = 16;
    localparam longint DEGQ = 65536;

    typedef struct packed {
        logic [7:0] da;
        logic [7:0] db;
        logic [7:0] dc;
        logic       rev;
        logic [1:0] sect;
    } drive_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0] m_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    joystick_to_three_pump_drive u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor copy of registers and button state
    longint cx = 512, cy = 512, mxa = 255, mxb = 255, mxc = 255, mnd = 0;
    bit rev_flag = 0, latch = 0;

    logic [20:0] sample_q[$];
    drive_res_t drive_q[$];
    int errors = 0, n_sent = 0, n_got = 0;
    int send_idle = 13, recv_idle = 51;
    bit hold_off = 0;
    longint cycles = 0;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_tab(int i);
        longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                          14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
        return t[i];
    endfunction

    function automatic longint direction_q16(longint dx, longint dy);
        longint x, y, z, base, xn, t;
        z = 0;
        base = 0;
        if (dy == 0) return dx >= 0 ? 0 : 180 * DEGQ;
        if (dx == 0) return dy > 0 ? 90 * DEGQ : 270 * DEGQ;
        x = dx * 4096;
        y = dy * 4096;
        if (x < 0) begin
            x = -x; y = -y; base = 180 * DEGQ;
        end
        for (int i = 0; i < NSTEP; i++) begin
            if (y > 0) begin
                xn = x + sra(y, i); y = y - sra(x, i); z += atan_tab(i);
            end else begin
                xn = x - sra(y, i); y = y + sra(x, i); z -= atan_tab(i);
            end
            x = xn;
        end
        t = base + z;
        if (t < 0) t += 360 * DEGQ;
        if (t >= 360 * DEGQ) t -= 360 * DEGQ;
        return t;
    endfunction

    function automatic longint high_part(longint s);
        longint x, y, z, xn, num, h;
        x = 1 << 20; y = 0; z = s;
        for (int i = 0; i < NSTEP; i++) begin
            if (z >= 0) begin
                xn = x - sra(y, i); y = y + sra(x, i); z -= atan_tab(i);
            end else begin
                xn = x + sra(y, i); y = y - sra(x, i); z += atan_tab(i);
            end
            x = xn;
        end
        if (x <= 0) return 16384;
        num = x + sra(y * 37837, 16);
        if (num <= 0) return 0;
        h = (num * 16384) / x;
        return h > 32768 ? 32768 : h;
    endfunction

    function automatic longint root_of(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] pump_level(longint share, longint len, longint mx, longint mn);
        longint num, q;
        if (mx == 0) return mn[7:0];
        num = share * len * (mx - mn) + mn * mx * (64'sd1 << 31);
        if (num <= 0) return 8'd0;
        q = num / (mx * (64'sd1 << 31));
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    // advance predictor state for one sample and return the expected drive
    function automatic drive_res_t predict_drive(logic [20:0] smp);
        drive_res_t r;
        longint dx, dy, th, s, hi, lo, len;
        bit btn;
        btn = smp[20];
        if (btn && !latch) begin
            rev_flag ^= 1'b1; latch = 1;
        end
        if (latch && !btn) latch = 0;
        dx = longint'(smp[9:0]) - cx;
        dy = longint'(smp[19:10]) - cy;
        th = direction_q16(dx, dy);
        if (rev_flag) begin
            th += 180 * DEGQ;
            if (th >= 360 * DEGQ) th -= 360 * DEGQ;
        end
        r = '0;
        if (th >= 30 * DEGQ && th < 150 * DEGQ) begin
            r.sect = SECT_0; s = th - 90 * DEGQ;
        end else if (th >= 150 * DEGQ && th < 270 * DEGQ) begin
            r.sect = SECT_1; s = th - 210 * DEGQ;
        end else begin
            r.sect = SECT_2;
            s = th >= 270 * DEGQ ? th - 330 * DEGQ : th + 30 * DEGQ;
        end
        hi = high_part(s);
        lo = 32768 - hi;
        len = root_of(dx * dx + dy * dy) * 45875;
        case (r.sect)
            SECT_0: begin
                r.db = pump_level(lo, len, mxb, mnd); r.dc = pump_level(hi, len, mxc, mnd);
            end
            SECT_1: begin
                r.dc = pump_level(lo, len, mxc, mnd); r.da = pump_level(hi, len, mxa, mnd);
            end
            default: begin
                r.da = pump_level(lo, len, mxa, mnd); r.db = pump_level(hi, len, mxb, mnd);
            end
        endcase
        r.rev = rev_flag;
        return r;
    endfunction

    // sample driver; while held off, each sample waits until every result is back
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) n_sent++;
                if (s_tvalid && s_tready) drive_q.push_back(predict_drive(s_tdata[20:0]));
                if (!(hold_off && drive_q.size() > 0) && sample_q.size() > 0
                    && $urandom_range(99) >= send_idle) begin
                    s_tdata <= {3'b0, sample_q.pop_front()};
                    s_tvalid <= 1'b1;
                end else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        drive_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser[0], m_tuser[2:1]};
                n_got++;
                if (drive_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = drive_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp a=%0d b=%0d c=%0d r=%0d s=%0d",
                                      " got a=%0d b=%0d c=%0d r=%0d s=%0d"},
                                     want.da, want.db, want.dc, want.rev, want.sect,
                                     got.da, got.db, got.dc, got.rev, got.sect);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input longint val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val[31:0];
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CENTER_X: cx = val & 1023;
            REG_CENTER_Y: cy = val & 1023;
            REG_MAX_A:    mxa = val & 255;
            REG_MAX_B:    mxb = val & 255;
            REG_MAX_C:    mxc = val & 255;
            default:      mnd = val & 255;
        endcase
    endtask

    // checked between edges so that the driver's updates have settled
    task automatic drain_wait();
        while (sample_q.size() > 0 || s_tvalid || drive_q.size() > 0) @(negedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic logic [20:0] mk(int x, int y, bit b);
        return {b, y[9:0], x[9:0]};
    endfunction

    // mostly well-formed joystick traffic: offsets near or far from centre, button held
    task automatic random_burst(int n);
        bit b;
        int x, y;
        b = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) b = ~b;
            case ($urandom_range(3))
                0: begin x = cx + $urandom_range(8) - 4; y = cy + $urandom_range(8) - 4; end
                1: begin x = $urandom_range(1023); y = cy; end
                default: begin x = $urandom_range(1023); y = $urandom_range(1023); end
            endcase
            if (x < 0) x = 0;
            if (x > 1023) x = 1023;
            if (y < 0) y = 0;
            if (y > 1023) y = 1023;
            sample_q.push_back(mk(x, y, b));
        end
    endtask

    task automatic set_regs(longint a, longint b, longint c, longint d, longint e, longint f);
        reg_write(REG_CENTER_X, a); reg_write(REG_CENTER_Y, b);
        reg_write(REG_MAX_A, c); reg_write(REG_MAX_B, d);
        reg_write(REG_MAX_C, e); reg_write(REG_MIN, f);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        set_regs(512, 512, 255, 255, 255, 0);

        // directed: centre, axes, corners, button edges, field extremes
        sample_q.push_back(mk(512, 512, 0));
        sample_q.push_back(mk(1023, 512, 0));
        sample_q.push_back(mk(0, 512, 0));
        sample_q.push_back(mk(512, 1023, 0));
        sample_q.push_back(mk(512, 0, 0));
        sample_q.push_back(mk(1023, 1023, 0));
        sample_q.push_back(mk(0, 0, 0));
        sample_q.push_back(mk(0, 1023, 1));
        sample_q.push_back(mk(1023, 0, 1));
        sample_q.push_back(mk(700, 620, 0));
        sample_q.push_back(mk(300, 400, 1));
        sample_q.push_back(mk(800, 300, 0));
        // sector boundaries near 30, 150 and 270 degrees
        sample_q.push_back(mk(512 + 433, 512 + 250, 0));
        sample_q.push_back(mk(512 - 433, 512 + 250, 0));
        sample_q.push_back(mk(512 + 1, 512 - 500, 0));
        drain_wait();

        // hold the sender back until everything has come out
        hold_off = 1;
        random_burst(50);
        drain_wait();
        hold_off = 0;

        // min above max, then extremes
        set_regs(0, 1023, 1, 128, 255, 200);
        sample_q.push_back(mk(1023, 0, 0));
        sample_q.push_back(mk(0, 1023, 1));
        random_burst(250);
        drain_wait();
        set_regs(1023, 0, 255, 1, 17, 255);
        random_burst(250);
        drain_wait();
        set_regs(300, 700, 200, 150, 100, 30);
        random_burst(400);
        drain_wait();

        send_idle = 51; recv_idle = 13;
        set_regs(512, 512, 255, 255, 255, 0);
        random_burst(450);
        drain_wait();
        send_idle = 0; recv_idle = 0;
        set_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(255, 1),
                 $urandom_range(255, 1), $urandom_range(255, 1), $urandom_range(255));
        random_burst(450);
        drain_wait();

        $display("Covered %0d samples and %0d results over six register settings,",
                 n_sent, n_got);
        $display("with button toggling, centre offsets, both idling mixes and a drained pause.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/jtpd_pkg.sv
hw/rtl/jtpd_cordic.sv
hw/rtl/jtpd_isqrt.sv
hw/rtl/jtpd_div.sv
hw/rtl/joystick_to_three_pump_drive.sv
dv/joystick_to_three_pump_drive_test.sv
